FILE: rtl/alse_pkg.sv
// ----------------------------------------------------------------------------
// alse_pkg: shared definitions for the array list statistics engine
// Command and status codes, field widths, and the sequencer control store.
// ----------------------------------------------------------------------------
package alse_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned MEAN_W     = 40;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned MW         = $clog2(RESULT_CAP + 1);

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_MAX    = 3'd2;
  localparam logic [2:0] CMD_MIN    = 3'd3;
  localparam logic [2:0] CMD_MEAN   = 3'd4;
  localparam logic [2:0] CMD_SEARCH = 3'd5;
  localparam logic [2:0] CMD_LIST   = 3'd6;
  localparam logic [2:0] CMD_NONE   = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    U_INS,
    U_FULL,
    U_EMPTY,
    U_RD0,
    U_HEAD,
    U_SHIFT,
    U_REM_OUT,
    U_EXT,
    U_EXT_OUT,
    U_SUM,
    U_DIV_INIT,
    U_DIV,
    U_MEAN_OUT,
    U_SRCH,
    U_SRCH_OUT,
    U_LIST
  } uop_e;

  // sequencing: next step, end, or conditional jump to target
  typedef enum logic [1:0] {
    J_NEXT,      // step + 1
    J_END,       // back to idle
    J_LOOP,      // cond ? target : step + 1
    J_LOOP_END   // cond ? target : idle
  } jmp_e;

  typedef logic [4:0] step_t;

  typedef struct packed {
    uop_e  op;
    jmp_e  jmp;
    step_t target;
  } uword_t;

  // program entry points and steps
  localparam step_t STEP_INS       = 5'd0;
  localparam step_t STEP_FULL      = 5'd1;
  localparam step_t STEP_EMPTY     = 5'd2;
  localparam step_t STEP_REM       = 5'd3;
  localparam step_t STEP_REM_HEAD  = 5'd4;
  localparam step_t STEP_REM_SHIFT = 5'd5;
  localparam step_t STEP_REM_OUT   = 5'd6;
  localparam step_t STEP_EXT       = 5'd7;
  localparam step_t STEP_EXT_LOOP  = 5'd8;
  localparam step_t STEP_EXT_OUT   = 5'd9;
  localparam step_t STEP_MEAN      = 5'd10;
  localparam step_t STEP_SUM       = 5'd11;
  localparam step_t STEP_DIV_INIT  = 5'd12;
  localparam step_t STEP_DIV       = 5'd13;
  localparam step_t STEP_MEAN_OUT  = 5'd14;
  localparam step_t STEP_SRCH      = 5'd15;
  localparam step_t STEP_SRCH_LOOP = 5'd16;
  localparam step_t STEP_SRCH_OUT  = 5'd17;
  localparam step_t STEP_LIST      = 5'd18;
  localparam step_t STEP_LIST_LOOP = 5'd19;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      STEP_INS:       w = '{U_INS,      J_END,      STEP_INS};
      STEP_FULL:      w = '{U_FULL,     J_END,      STEP_INS};
      STEP_EMPTY:     w = '{U_EMPTY,    J_END,      STEP_INS};
      STEP_REM:       w = '{U_RD0,      J_NEXT,     STEP_INS};
      STEP_REM_HEAD:  w = '{U_HEAD,     J_LOOP,     STEP_REM_OUT};
      STEP_REM_SHIFT: w = '{U_SHIFT,    J_LOOP,     STEP_REM_SHIFT};
      STEP_REM_OUT:   w = '{U_REM_OUT,  J_END,      STEP_INS};
      STEP_EXT:       w = '{U_RD0,      J_NEXT,     STEP_INS};
      STEP_EXT_LOOP:  w = '{U_EXT,      J_LOOP,     STEP_EXT_LOOP};
      STEP_EXT_OUT:   w = '{U_EXT_OUT,  J_END,      STEP_INS};
      STEP_MEAN:      w = '{U_RD0,      J_NEXT,     STEP_INS};
      STEP_SUM:       w = '{U_SUM,      J_LOOP,     STEP_SUM};
      STEP_DIV_INIT:  w = '{U_DIV_INIT, J_NEXT,     STEP_INS};
      STEP_DIV:       w = '{U_DIV,      J_LOOP,     STEP_DIV};
      STEP_MEAN_OUT:  w = '{U_MEAN_OUT, J_END,      STEP_INS};
      STEP_SRCH:      w = '{U_RD0,      J_NEXT,     STEP_INS};
      STEP_SRCH_LOOP: w = '{U_SRCH,     J_LOOP,     STEP_SRCH_LOOP};
      STEP_SRCH_OUT:  w = '{U_SRCH_OUT, J_END,      STEP_INS};
      STEP_LIST:      w = '{U_RD0,      J_NEXT,     STEP_INS};
      STEP_LIST_LOOP: w = '{U_LIST,     J_LOOP_END, STEP_LIST_LOOP};
      default:        w = '{U_EMPTY,    J_END,      STEP_INS};
    endcase
    return w;
  endfunction

  // operations that may load the result register
  function automatic logic uop_emits(uop_e op);
    logic e;
    case (op)
      U_INS, U_FULL, U_EMPTY, U_REM_OUT, U_EXT_OUT, U_MEAN_OUT,
      U_SRCH, U_SRCH_OUT, U_LIST: e = 1'b1;
      default:                    e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/array_list_stats_engine.sv
// ----------------------------------------------------------------------------
// array_list_stats_engine: list of signed values with min/max/mean/search
// Microcoded sequencer over a simple dual-port element store and a shared datapath.
// ----------------------------------------------------------------------------
// Command flow (n = element count, DVW = 32 + clog2(DEPTH) + 8):
//   insert and error results load directly; remove, max, min scan the n elements;
//   mean sums the n elements, then runs a DVW-bit restoring divide (44 bits at DEPTH = 16);
//   search scans one element per cycle, list gives one item per cycle, while results are not stalled.
// One command at a time: next item taken the cycle after its last result loads.
// Reset clears the count and control; the store keeps its contents (no clear).
module array_list_stats_engine
  import alse_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [POS_W-1:0]         position_o,
  output logic signed [MEAN_W-1:0] mean_q8_o,
  output logic                     found_o,
  output logic                     last_o
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SUMW = DATA_W + IDXW;   // sum of up to DEPTH values
  localparam int unsigned DVW  = SUMW + FRAC_W;   // |sum| * 256
  localparam int unsigned BW   = $clog2(DVW + 1);

  // --- sequencer state
  logic    busy_q, busy_d;
  step_t   step_q, step_d;
  uword_t  uw;
  logic    emits, stall, adv, cond;

  // --- datapath registers
  logic [2:0]        cmd_q, cmd_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic [DATA_W-1:0] acc_q, acc_d;      // head, extremum or pending match
  logic [IDXW-1:0]   pos_q, pos_d;      // index of pending match
  logic              pend_q, pend_d;
  logic [MW-1:0]     m_q, m_d;          // matches seen
  logic [SUMW-1:0]   sum_q, sum_d;
  logic [DVW-1:0]    dq_q, dq_d;        // dividend shifting out, quotient in
  logic [CW-1:0]     rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [BW-1:0]     bit_q, bit_d;

  // --- element store
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              rd_en, wr_en;
  logic [IDXW-1:0]   raddr, waddr;
  logic [DATA_W-1:0] wdata;

  // --- result register
  logic              out_valid_q, out_load;
  logic [1:0]        o_status_q, o_status_d;
  logic [DATA_W-1:0] o_data_q, o_data_d;
  logic [POS_W-1:0]  o_pos_q, o_pos_d;
  logic [MEAN_W-1:0] o_mean_q, o_mean_d;
  logic              o_found_q, o_found_d;
  logic              o_last_q, o_last_d;

  // --- helpers
  logic              in_accept;
  logic [CW-1:0]     idx_nx, idx_nx2;
  logic              match, better;
  logic [CW:0]       trial;
  logic              ge;
  logic [SUMW-1:0]   mag;
  logic [DVW-1:0]    quot;

  assign in_ready_o = !busy_q;
  assign in_accept  = in_valid_i && in_ready_o;

  assign uw    = ucode(step_q);
  assign emits = uop_emits(uw.op);
  // an emitting step waits until the result register can take a new item
  assign stall = emits && out_valid_q && !out_ready_i;
  assign adv   = busy_q && !stall;

  assign idx_nx  = CW'(idx_q) + CW'(1);
  assign idx_nx2 = CW'(idx_q) + CW'(2);
  assign match   = (rdata_q == val_q);
  assign better  = (cmd_q == CMD_MAX) ? ($signed(rdata_q) > $signed(acc_q))
                                      : ($signed(rdata_q) < $signed(acc_q));
  assign trial   = {rem_q, dq_q[DVW-1]};
  assign ge      = (trial >= {1'b0, cnt_q});
  assign mag     = sum_q[SUMW-1] ? (~sum_q + SUMW'(1)) : sum_q;
  assign quot    = neg_q ? (~dq_q + DVW'(1)) : dq_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cmd_d  = cmd_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    acc_d  = acc_q;
    pos_d  = pos_q;
    pend_d = pend_q;
    m_d    = m_q;
    sum_d  = sum_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    bit_d  = bit_q;
    cond   = 1'b0;

    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = '0;
    wdata = rdata_q;

    out_load   = 1'b0;
    o_status_d = STAT_OK;
    o_data_d   = '0;
    o_pos_d    = '0;
    o_mean_d   = '0;
    o_found_d  = 1'b0;
    o_last_d   = 1'b1;

    // dispatch: pick the program entry, errors go straight to their step
    if (in_accept && cmd_i != CMD_NONE) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      val_d  = value_i;
      case (cmd_i)
        CMD_INSERT: step_d = (cnt_q == CW'(DEPTH)) ? STEP_FULL : STEP_INS;
        CMD_REMOVE: step_d = STEP_REM;
        CMD_MAX:    step_d = STEP_EXT;
        CMD_MIN:    step_d = STEP_EXT;
        CMD_MEAN:   step_d = STEP_MEAN;
        CMD_SEARCH: step_d = STEP_SRCH;
        CMD_LIST:   step_d = STEP_LIST;
        default:    step_d = STEP_INS;
      endcase
      if (cmd_i != CMD_INSERT && cnt_q == '0) begin
        step_d = STEP_EMPTY;
      end
    end

    if (adv) begin
      case (uw.op)
        U_INS: begin
          wr_en    = 1'b1;
          waddr    = IDXW'(cnt_q);
          wdata    = val_q;
          cnt_d    = cnt_q + CW'(1);
          out_load = 1'b1;
          o_data_d = val_q;
          o_pos_d  = POS_W'(cnt_q);
        end
        U_FULL: begin
          out_load   = 1'b1;
          o_status_d = STAT_FULL;
        end
        U_EMPTY: begin
          out_load   = 1'b1;
          o_status_d = STAT_EMPTY;
        end
        U_RD0: begin
          rd_en  = 1'b1;
          raddr  = '0;
          idx_d  = '0;
          m_d    = '0;
          pend_d = 1'b0;
          sum_d  = '0;
        end
        U_HEAD: begin
          acc_d = rdata_q;
          rd_en = 1'b1;
          raddr = IDXW'(1);
          cond  = (cnt_q == CW'(1));   // single element: nothing to shift
        end
        U_SHIFT: begin
          // rdata holds entry idx+1, move it down one slot
          wr_en = 1'b1;
          waddr = idx_q;
          wdata = rdata_q;
          rd_en = 1'b1;
          raddr = IDXW'(idx_nx2);
          idx_d = IDXW'(idx_nx);
          cond  = (idx_nx2 < cnt_q);
        end
        U_REM_OUT: begin
          cnt_d    = cnt_q - CW'(1);
          out_load = 1'b1;
          o_data_d = acc_q;
        end
        U_EXT: begin
          if (idx_q == '0 || better) begin
            acc_d = rdata_q;
          end
          rd_en = 1'b1;
          raddr = IDXW'(idx_nx);
          idx_d = IDXW'(idx_nx);
          cond  = (idx_nx < cnt_q);
        end
        U_EXT_OUT: begin
          out_load = 1'b1;
          o_data_d = acc_q;
        end
        U_SUM: begin
          sum_d = sum_q + {{(SUMW - DATA_W){rdata_q[DATA_W-1]}}, rdata_q};
          rd_en = 1'b1;
          raddr = IDXW'(idx_nx);
          idx_d = IDXW'(idx_nx);
          cond  = (idx_nx < cnt_q);
        end
        U_DIV_INIT: begin
          dq_d  = {mag, FRAC_W'(0)};
          rem_d = '0;
          neg_d = sum_q[SUMW-1];
          bit_d = BW'(DVW);
        end
        U_DIV: begin
          // restoring step: one quotient bit per cycle
          rem_d = ge ? CW'(trial - {1'b0, cnt_q}) : CW'(trial);
          dq_d  = {dq_q[DVW-2:0], ge};
          bit_d = bit_q - BW'(1);
          cond  = (bit_q != BW'(1));
        end
        U_MEAN_OUT: begin
          out_load = 1'b1;
          o_mean_d = MEAN_W'(quot);
        end
        U_SRCH: begin
          // a match is held back one step so the final one can carry last
          if (match) begin
            if (pend_q) begin
              out_load  = 1'b1;
              o_data_d  = acc_q;
              o_pos_d   = POS_W'(pos_q);
              o_found_d = 1'b1;
              o_last_d  = 1'b0;
            end
            acc_d  = rdata_q;
            pos_d  = idx_q;
            pend_d = 1'b1;
            m_d    = m_q + MW'(1);
          end
          rd_en = 1'b1;
          raddr = IDXW'(idx_nx);
          idx_d = IDXW'(idx_nx);
          cond  = (idx_nx < cnt_q) && !(match && (m_q + MW'(1) == MW'(RESULT_CAP)));
        end
        U_SRCH_OUT: begin
          out_load = 1'b1;
          if (pend_q) begin
            o_data_d  = acc_q;
            o_pos_d   = POS_W'(pos_q);
            o_found_d = 1'b1;
          end
        end
        U_LIST: begin
          cond     = (idx_nx < cnt_q) && (32'(idx_nx) != RESULT_CAP);
          out_load = 1'b1;
          o_data_d = rdata_q;
          o_pos_d  = POS_W'(idx_q);
          o_last_d = !cond;
          rd_en    = 1'b1;
          raddr    = IDXW'(idx_nx);
          idx_d    = IDXW'(idx_nx);
        end
        default: begin
          out_load = 1'b0;
        end
      endcase

      case (uw.jmp)
        J_NEXT:  step_d = step_q + step_t'(1);
        J_END:   busy_d = 1'b0;
        J_LOOP:  step_d = cond ? uw.target : step_q + step_t'(1);
        J_LOOP_END: begin
          if (cond) begin
            step_d = uw.target;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_INS;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      m_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      pend_q <= pend_d;
      m_q    <= m_d;
      bit_q  <= bit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    acc_q <= acc_d;
    pos_q <= pos_d;
    sum_q <= sum_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    if (out_load) begin
      o_status_q <= o_status_d;
      o_data_q   <= o_data_d;
      o_pos_q    <= o_pos_d;
      o_mean_q   <= o_mean_d;
      o_found_q  <= o_found_d;
      o_last_q   <= o_last_d;
    end
  end

  // element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_status_q;
  assign data_o      = o_data_q;
  assign position_o  = o_pos_q;
  assign mean_q8_o   = o_mean_q;
  assign found_o     = o_found_q;
  assign last_o      = o_last_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("element count beyond capacity");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i != CMD_NONE) |=> busy_q)
    else $error("accepted command did not start the sequencer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("result register overwritten before taken");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == STEP_DIV) |-> (rem_q < cnt_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sim/tb_array_list_stats_engine.sv
// ----------------------------------------------------------------------------
// tb_array_list_stats_engine: self-checking bench for the list statistics engine
// Drives insert/remove/max/min/mean/search/list commands through the item
// handshake, predicts every result from a shadow copy of the list, and checks
// each result field by field in arrival order under several idle patterns.
// ----------------------------------------------------------------------------
module tb_array_list_stats_engine;
  import alse_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int ITEM_TARGET     = 370;
  localparam int WATCHDOG_CYCLES = 4000;  // quiet cycles before giving up
  localparam int TAIL_CYCLES     = 100;   // longest command is mean

  typedef struct {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic signed [MEAN_W-1:0] mean_q8;
    logic                     found;
    logic                     last;
  } list_reply_t;

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic [2:0]               cmd        = CMD_NONE;
  logic signed [DATA_W-1:0] value      = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [POS_W-1:0]         position;
  logic signed [MEAN_W-1:0] mean_q8;
  logic                     found;
  logic                     last;

  // command items waiting to be driven, and results waiting to arrive
  list_cmd_t                pending_cmds[$];
  list_reply_t              awaited_replies[$];

  // shadow of the engine's store, updated as items are accepted
  logic signed [DATA_W-1:0] shadow_list[DEPTH];
  int                       shadow_count = 0;

  // generator-side view of the list, used only to shape the stimulus
  logic signed [DATA_W-1:0] plan_list[$];
  int                       cmds_queued = 0;

  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  logic                     cmd_taken      = 1'b0;
  int                       errors         = 0;
  list_cmd_t                next_cmd;
  list_reply_t              got, want;

  array_list_stats_engine i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .data_o      (data),
    .position_o  (position),
    .mean_q8_o   (mean_q8),
    .found_o     (found),
    .last_o      (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void push_reply(logic [1:0] st, logic signed [DATA_W-1:0] d,
                                     logic [POS_W-1:0] pos, logic signed [MEAN_W-1:0] m,
                                     logic fnd, logic lst);
    list_reply_t r;
    r.status   = st;
    r.data     = d;
    r.position = pos;
    r.mean_q8  = m;
    r.found    = fnd;
    r.last     = lst;
    awaited_replies.push_back(r);
  endfunction

  function automatic void apply_list_command(logic [2:0] op, logic signed [DATA_W-1:0] val);
    longint                   sum;
    logic signed [DATA_W-1:0] best;
    int                       hits;
    if (op == CMD_NONE) return;
    if (op == CMD_INSERT) begin
      if (shadow_count >= DEPTH) begin
        push_reply(STAT_FULL, '0, '0, '0, 1'b0, 1'b1);
      end else begin
        shadow_list[shadow_count] = val;
        push_reply(STAT_OK, val, POS_W'(shadow_count), '0, 1'b0, 1'b1);
        shadow_count++;
      end
      return;
    end
    if (shadow_count == 0) begin
      push_reply(STAT_EMPTY, '0, '0, '0, 1'b0, 1'b1);
      return;
    end
    case (op)
      CMD_REMOVE: begin
        best = shadow_list[0];
        for (int i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
        push_reply(STAT_OK, best, '0, '0, 1'b0, 1'b1);
      end
      CMD_MAX, CMD_MIN: begin
        best = shadow_list[0];
        for (int i = 1; i < shadow_count; i++) begin
          if (op == CMD_MAX ? (shadow_list[i] > best) : (shadow_list[i] < best))
            best = shadow_list[i];
        end
        push_reply(STAT_OK, best, '0, '0, 1'b0, 1'b1);
      end
      CMD_MEAN: begin
        sum = 0;
        for (int i = 0; i < shadow_count; i++) sum += longint'(shadow_list[i]);
        // signed 64-bit division truncates toward zero
        push_reply(STAT_OK, '0, '0, MEAN_W'((sum * 256) / shadow_count), 1'b0, 1'b1);
      end
      CMD_SEARCH: begin
        hits = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == val && hits < RESULT_CAP) begin
            push_reply(STAT_OK, shadow_list[i], POS_W'(i), '0, 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) push_reply(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
        else awaited_replies[awaited_replies.size() - 1].last = 1'b1;
      end
      default: begin
        for (int i = 0; i < shadow_count && i < RESULT_CAP; i++)
          push_reply(STAT_OK, shadow_list[i], POS_W'(i), '0, 1'b0, 1'b0);
        awaited_replies[awaited_replies.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new item or idle at the falling edge, receiver stalls at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || cmd_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        cmd      <= next_cmd.op;
        value    <= next_cmd.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted commands, check accepted results
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) apply_list_command(cmd, value);
      if (out_valid && out_ready) begin
        got.status   = status;
        got.data     = data;
        got.position = position;
        got.mean_q8  = mean_q8;
        got.found    = found;
        got.last     = last;
        if (awaited_replies.size() == 0) begin
          $error("unexpected result: status %0d data %0d position %0d",
                 got.status, got.data, got.position);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, got.data);
            errors++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            errors++;
          end
          if (got.mean_q8 !== want.mean_q8) begin
            $error("mean_q8: expected %0d, got %0d", want.mean_q8, got.mean_q8);
            errors++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: a hung handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_cmd(logic [2:0] op, logic signed [DATA_W-1:0] v);
    list_cmd_t c;
    c.op    = op;
    c.value = v;
    pending_cmds.push_back(c);
    if (op != CMD_NONE) cmds_queued++;
    if (op == CMD_INSERT && plan_list.size() < DEPTH) plan_list.push_back(v);
    if (op == CMD_REMOVE && plan_list.size() != 0) void'(plan_list.pop_front());
  endtask

  // extremes and a small pool give ties and repeated matches
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return DATA_W'(int'($urandom_range(4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // half the searches hit something that is stored
  function automatic logic signed [DATA_W-1:0] search_value();
    if (plan_list.size() != 0 && $urandom_range(1) == 1)
      return plan_list[$urandom_range(plan_list.size() - 1)];
    return pick_value();
  endfunction

  // fill up with one value: full-list insert and a search for that value
  task automatic fill_uniform(logic signed [DATA_W-1:0] v);
    while (plan_list.size() < DEPTH) queue_cmd(CMD_INSERT, v);
    queue_cmd(CMD_INSERT, pick_value());
    queue_cmd(CMD_SEARCH, v);
    queue_cmd(CMD_LIST, $urandom);
    queue_cmd(CMD_MEAN, $urandom);
  endtask

  // sender holds off until every result is in
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || awaited_replies.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int                       sel;
    int                       goal;
    int                       k;
    logic [2:0]               op;
    logic signed [DATA_W-1:0] v;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every command on an empty list, the unused code, extremes,
    // a search miss, a remove shift and a negative mean
    queue_cmd(CMD_REMOVE, '0);
    queue_cmd(CMD_MAX, '0);
    queue_cmd(CMD_MIN, '1);
    queue_cmd(CMD_MEAN, '0);
    queue_cmd(CMD_SEARCH, '0);
    queue_cmd(CMD_LIST, '1);
    queue_cmd(CMD_NONE, 32'sh1234_5678);
    queue_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    queue_cmd(CMD_INSERT, 32'sh8000_0000);
    queue_cmd(CMD_INSERT, '0);
    queue_cmd(CMD_INSERT, -1);
    queue_cmd(CMD_MAX, '0);
    queue_cmd(CMD_MIN, '0);
    queue_cmd(CMD_MEAN, '0);
    queue_cmd(CMD_SEARCH, -1);
    queue_cmd(CMD_SEARCH, 5);
    queue_cmd(CMD_LIST, '0);
    queue_cmd(CMD_REMOVE, '0);
    queue_cmd(CMD_LIST, '0);
    queue_cmd(CMD_MEAN, '0);
    wait_drained();

    // random part in four idle phases, drained between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      goal = cmds_queued + (ITEM_TARGET - cmds_queued) / (4 - ph);
      if (ph == 0) fill_uniform(pick_value());
      while (cmds_queued < goal) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          // burst of inserts, may run past full, then queries
          k = $urandom_range(18, 1);
          repeat (k) queue_cmd(CMD_INSERT, pick_value());
          queue_cmd(CMD_SEARCH, search_value());
          queue_cmd($urandom_range(1) ? CMD_MAX : CMD_MIN, $urandom);
          queue_cmd(CMD_MEAN, $urandom);
        end else if (sel < 40) begin
          fill_uniform(pick_value());
        end else if (sel < 55) begin
          // drain to empty and one past
          while (plan_list.size() != 0) queue_cmd(CMD_REMOVE, $urandom);
          queue_cmd(CMD_REMOVE, $urandom);
          queue_cmd(3'($urandom_range(6, 1)), $urandom);
        end else if (sel < 95) begin
          repeat (6) begin
            op = 3'($urandom_range(6));
            if (op == CMD_INSERT) v = pick_value();
            else if (op == CMD_SEARCH) v = search_value();
            else v = $urandom;
            queue_cmd(op, v);
          end
        end else begin
          // unused code mixed with a real command
          queue_cmd(CMD_NONE, $urandom);
          queue_cmd(3'($urandom_range(6)), search_value());
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: array_list_stats_engine.f
rtl/alse_pkg.sv
rtl/array_list_stats_engine.sv
sim/tb_array_list_stats_engine.sv
